FILE: rtl/tcw_pkg.sv
// Shared constants and codes for the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int MODE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    typedef logic [CELL_W-1:0] cell_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_top.sv
// Top level of the character-cell text console writer.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   mode, char_code, cell_index
//  out      output     out_valid / out_ready cell_data, cursor_pos, caret
//  cfg      input      cfg_we (no wait)      cfg_index, cfg_data
//
// A read, newline, ignored backspace or unused mode passes from acceptance through EXEC
// and FINISH to the result register; a printable character or backspace also passes
// through PUT. Each scroll adds a pass of SCROLL over the screen and a clear is a pass of
// CLEAR; both walk the screen store through its single read and single write port. After
// reset the store is zeroed by a pass over all COLUMNS*ROWS cells, during which no item is
// taken. The result register parts the two sides: a new item is taken while a result
// waits, and only the final hand-over waits for out_ready.
`default_nettype none

module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int IDX_W   = $clog2(CELLS),
    localparam int CARET_W = $clog2(2 * CELLS + 1)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tcw_pkg::MODE_W-1:0]       mode,
    input  wire logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  wire logic [IDX_W-1:0]                 cell_index,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tcw_pkg::CELL_W-1:0]            cell_data,
    output logic [IDX_W-1:0]                      cursor_pos,
    output logic [CARET_W-1:0]                    caret,

    input  wire logic                             cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]      cfg_data
);

    import tcw_pkg::*;

    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_PUT    = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CARET_W-1:0] caret_reg, caret_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               out_valid_reg, out_valid_next;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               bs_reg, bs_next;
    cell_t              data_reg, data_next;
    cell_t              cell_data_reg, cell_data_next;
    logic [IDX_W-1:0]   cursor_out_reg, cursor_out_next;
    logic [CARET_W-1:0] caret_out_reg, caret_out_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    cell_t              ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    cell_t              ram_rdata;

    cell_t              space_cell;
    logic [CARET_W:0]   nl_next;
    logic [CARET_W:0]   nl_sat;
    logic [CARET_W:0]   caret_inc;
    logic [CARET_W:0]   caret_dec_row;
    logic [CNT_W:0]     scroll_src;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_data  = cell_data_reg;
    assign cursor_pos = cursor_out_reg;
    assign caret      = caret_out_reg;

    assign space_cell    = {bg_reg, fg_reg, CH_SPACE};
    assign caret_inc     = {1'b0, caret_reg} + (CARET_W+1)'(1);
    assign caret_dec_row = {1'b0, caret_reg} - (CARET_W+1)'(COLUMNS);
    // The column register tracks caret modulo COLUMNS, so the next line start needs no divide.
    assign nl_next       = {1'b0, caret_reg} - (CARET_W+1)'(col_reg) + (CARET_W+1)'(COLUMNS);
    assign nl_sat        = (nl_next > (CARET_W+1)'(2 * CELLS)) ? (CARET_W+1)'(2 * CELLS)
                                                                : nl_next;
    assign scroll_src    = {1'b0, cnt_reg} + (CNT_W+1)'(COLUMNS);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        caret_next      = caret_reg;
        col_next        = col_reg;
        cursor_next     = cursor_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mode_next       = mode_reg;
        ch_next         = ch_reg;
        idx_next        = idx_reg;
        bs_next         = bs_reg;
        data_next       = data_reg;
        cell_data_next  = cell_data_reg;
        cursor_out_next = cursor_out_reg;
        caret_out_next  = caret_out_reg;
        ram_we          = 1'b0;
        ram_waddr       = IDX_W'(cnt_reg);
        ram_wdata       = space_cell;
        ram_raddr       = cell_index;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FG_COLOR: fg_next = cfg_data;
                CFG_BG_COLOR: bg_next = cfg_data;
                default:      fg_next = fg_reg;
            endcase
        end

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    ch_next    = char_code;
                    idx_next   = cell_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                data_next  = '0;
                state_next = ST_FINISH;
                case (mode_reg)
                    MODE_READ:
                    begin
                        if ({1'b0, idx_reg} < (IDX_W+1)'(CELLS))
                        begin
                            data_next = ram_rdata;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    MODE_WRITE:
                    begin
                        if (ch_reg == CH_BACKSPACE)
                        begin
                            if (caret_reg != '0)
                            begin
                                // Step back and blank that cell, keeping the caret on it.
                                caret_next = caret_reg - CARET_W'(1);
                                col_next   = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                             : col_reg - COL_W'(1);
                                bs_next    = 1'b1;
                                ch_next    = CH_SPACE;
                                state_next = ST_PUT;
                            end
                        end
                        else if (ch_reg == CH_NEWLINE)
                        begin
                            caret_next = CARET_W'(nl_sat);
                            col_next   = '0;
                            if ((nl_sat + (CARET_W+1)'(1)) < (CARET_W+1)'(CELLS))
                            begin
                                cursor_next = IDX_W'(nl_sat + (CARET_W+1)'(1));
                            end
                        end
                        else
                        begin
                            bs_next    = 1'b0;
                            state_next = ST_PUT;
                        end
                    end
                    default:
                    begin
                        data_next = '0;
                    end
                endcase
            end

            ST_PUT:
            begin
                if (caret_reg >= CARET_W'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCROLL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(caret_reg);
                    ram_wdata = {bg_reg, fg_reg, ch_reg};
                    if (bs_reg)
                    begin
                        cursor_next = IDX_W'(caret_reg);
                    end
                    else
                    begin
                        caret_next = CARET_W'(caret_inc);
                        col_next   = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                     : col_reg + COL_W'(1);
                        if (caret_inc < (CARET_W+1)'(CELLS))
                        begin
                            cursor_next = IDX_W'(caret_inc);
                        end
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_SCROLL:
            begin
                // Read one line ahead while writing the cell behind; the last line is blanked.
                ram_raddr = IDX_W'(scroll_src);
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(cnt_reg - CNT_W'(1));
                    ram_wdata = (cnt_reg <= CNT_W'(CELLS - COLUMNS)) ? ram_rdata : space_cell;
                end
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    caret_next = CARET_W'(caret_dec_row);
                    if (caret_dec_row < (CARET_W+1)'(CELLS))
                    begin
                        cursor_next = IDX_W'(caret_dec_row);
                    end
                    state_next = ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cursor_next = IDX_W'(CELLS - 1);
                    caret_next  = '0;
                    col_next    = '0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cell_data_next  = data_reg;
                    cursor_out_next = cursor_reg;
                    caret_out_next  = caret_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            caret_reg     <= '0;
            col_reg       <= '0;
            cursor_reg    <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            caret_reg     <= caret_next;
            col_reg       <= col_next;
            cursor_reg    <= cursor_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        ch_reg         <= ch_next;
        idx_reg        <= idx_next;
        bs_reg         <= bs_next;
        data_reg       <= data_next;
        cell_data_reg  <= cell_data_next;
        cursor_out_reg <= cursor_out_next;
        caret_out_reg  <= caret_out_next;
    end

endmodule

`default_nettype wire

FILE: verif/text_console_writer_checker.sv
// Checker for the text console writer: tracks the screen, predicts each result and compares it.
`timescale 1ns / 1ps

module text_console_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int IDX_W   = $clog2(CELLS),
    localparam int CARET_W = $clog2(2 * CELLS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [tcw_pkg::MODE_W-1:0]       mode,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [IDX_W-1:0]                 cell_index,

    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [tcw_pkg::CELL_W-1:0]       cell_data,
    input  logic [IDX_W-1:0]                 cursor_pos,
    input  logic [CARET_W-1:0]               caret,

    input  logic                             cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,

    output int                               fail_count,
    output int                               outstanding,
    output int                               scroll_count,
    output int                               checked_count
);
    import tcw_pkg::*;

    typedef struct packed {
        cell_t                data;
        logic [IDX_W-1:0]     cursor;
        logic [CARET_W-1:0]   caret_val;
    } console_view_t;

    cell_t               screen_image [CELLS];
    int                  caret_at;
    int                  cursor_at;
    logic [COLOR_W-1:0]  fg_now;
    logic [COLOR_W-1:0]  bg_now;
    console_view_t       expected_views [$];
    console_view_t       want;

    function automatic cell_t shade(input logic [CHAR_W-1:0] ch);
        return {bg_now, fg_now, ch};
    endfunction

    // Moves to positions off the screen leave the cursor where it was.
    function void set_cursor(input int pos);
        if (pos < CELLS)
            cursor_at = pos;
    endfunction

    function void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_image[i] = screen_image[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_image[i] = shade(CH_SPACE);
        scroll_count++;
    endfunction

    function void place_glyph(input logic [CHAR_W-1:0] ch);
        while (caret_at >= CELLS)
        begin
            scroll_screen();
            caret_at -= COLUMNS;
            set_cursor(caret_at);
        end
        set_cursor(caret_at + 1);
        screen_image[caret_at] = shade(ch);
        caret_at++;
    endfunction

    function void take_char(input logic [CHAR_W-1:0] ch);
        int next_line;
        if (ch == CH_BACKSPACE)
        begin
            if (caret_at == 0)
                return;
            // The erased cell is written like any other character, so it may scroll first.
            caret_at--;
            place_glyph(CH_SPACE);
            caret_at--;
            set_cursor(caret_at);
        end
        else if (ch == CH_NEWLINE)
        begin
            next_line = (caret_at / COLUMNS + 1) * COLUMNS;
            if (next_line > 2 * CELLS)
                next_line = 2 * CELLS;
            caret_at = next_line;
            set_cursor(caret_at + 1);
        end
        else
            place_glyph(ch);
    endfunction

    function void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_image[i] = shade(CH_SPACE);
        set_cursor(CELLS - 1);
        caret_at = 0;
    endfunction

    function console_view_t predict_view(input logic [MODE_W-1:0] m,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] ix);
        console_view_t v;
        v.data = '0;
        case (m)
            MODE_WRITE: take_char(ch);
            MODE_READ:
            begin
                if (ix < CELLS)
                    v.data = screen_image[ix];
            end
            MODE_CLEAR: blank_screen();
            default: ;
        endcase
        v.cursor = cursor_at[IDX_W-1:0];
        v.caret_val = caret_at[CARET_W-1:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen_image[i] = '0;
            caret_at = 0;
            cursor_at = 0;
            fg_now = FG_RESET;
            bg_now = BG_RESET;
            expected_views.delete();
            fail_count = 0;
            outstanding = 0;
            scroll_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FG_COLOR)
                    fg_now = cfg_data;
                else if (cfg_index == CFG_BG_COLOR)
                    bg_now = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result with nothing expected: cell_data %h cursor_pos %0d caret %0d",
                           cell_data, cursor_pos, caret);
                    fail_count++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    checked_count++;
                    if (cell_data !== want.data)
                    begin
                        $error("cell_data: expected %h, actual %h", want.data, cell_data);
                        fail_count++;
                    end
                    if (cursor_pos !== want.cursor)
                    begin
                        $error("cursor_pos: expected %0d, actual %0d", want.cursor, cursor_pos);
                        fail_count++;
                    end
                    if (caret !== want.caret_val)
                    begin
                        $error("caret: expected %0d, actual %0d", want.caret_val, caret);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_views.push_back(predict_view(mode, char_code, cell_index));
            outstanding = expected_views.size();
        end
    end

endmodule

FILE: verif/text_console_writer_top_test.sv
// Testbench top for the text console writer: stimulus, colour settings, watchdog and verdict.
`timescale 1ns / 1ps

module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int IDX_W        = $clog2(CELLS);
    localparam int CARET_W      = $clog2(2 * CELLS + 1);
    localparam int IDX_MAX      = (1 << IDX_W) - 1;
    localparam int STALL_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASES       = 4;

    // The block has no fourth mode; items carrying it must change nothing.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode;
    logic [CHAR_W-1:0]     char_code;
    logic [IDX_W-1:0]      cell_index;
    logic                  out_valid;
    logic                  out_ready;
    logic [CELL_W-1:0]     cell_data;
    logic [IDX_W-1:0]      cursor_pos;
    logic [CARET_W-1:0]    caret;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COLOR_W-1:0]    cfg_data;

    int fail_count;
    int outstanding;
    int scroll_count;
    int checked_count;
    int quiet_cycles = 0;
    int n_sent = 0;
    int n_chars = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_unused = 0;
    int target;
    bit idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_data  (cell_data),
        .cursor_pos (cursor_pos),
        .caret      (caret),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    text_console_writer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cell_data     (cell_data),
        .cursor_pos    (cursor_pos),
        .caret         (caret),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .scroll_count  (scroll_count),
        .checked_count (checked_count)
    );

    // Any cycle without a handshake on either side counts towards the stall limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: ready most of the time, with random stalls while idling is enabled.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [CHAR_W-1:0] any_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom_range(0, IDX_MAX));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] ix);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        char_code <= ch;
        cell_index <= ix;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        n_sent++;
        case (m)
            MODE_WRITE: n_chars++;
            MODE_READ:  n_reads++;
            MODE_CLEAR: n_clears++;
            default:    n_unused++;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FG_COLOR;
        cfg_data <= fg;
        @(negedge clk);
        cfg_index <= CFG_BG_COLOR;
        cfg_data <= bg;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_step();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            send_item(MODE_WRITE, any_byte(), any_index());
        else if (pick < 38)
            send_item(MODE_WRITE, CH_NEWLINE, any_index());
        else if (pick < 46)
            send_item(MODE_WRITE, CH_BACKSPACE, any_index());
        else if (pick < 76)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(MODE_READ, any_byte(), IDX_W'($urandom_range(CELLS, IDX_MAX)));
            else
                send_item(MODE_READ, any_byte(), IDX_W'($urandom_range(0, CELLS - 1)));
        end
        else if (pick < 80)
            send_item(MODE_CLEAR, any_byte(), any_index());
        else if (pick < 82)
            send_item(MODE_UNUSED, any_byte(), any_index());
        else if (pick < 98)
        begin
            // A line of ordinary text ended by a newline.
            len = $urandom_range(5, 40);
            repeat (len)
                send_item(MODE_WRITE, CHAR_W'($urandom_range(32, 126)), any_index());
            send_item(MODE_WRITE, CH_NEWLINE, any_index());
        end
        else
        begin
            // A run of newlines drives the caret well past the screen, often to its ceiling,
            // so that the next character has to scroll many times over.
            len = $urandom_range(30, 55);
            repeat (len)
                send_item(MODE_WRITE, CH_NEWLINE, any_index());
            if ($urandom_range(0, 1) == 0)
                send_item(MODE_WRITE, CH_BACKSPACE, any_index());
            else
                send_item(MODE_WRITE, CHAR_W'($urandom_range(32, 126)), any_index());
            send_item(MODE_READ, any_byte(), IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_WRITE;
        char_code = '0;
        cell_index = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FG_COLOR;
        cfg_data = '0;
        idle_on = 1'b1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part with the colours left at their reset values.
        send_item(MODE_READ, 8'h00, IDX_W'(0));
        send_item(MODE_READ, 8'hFF, IDX_W'(CELLS - 1));
        send_item(MODE_READ, 8'h00, IDX_W'(CELLS));
        send_item(MODE_READ, 8'hFF, IDX_W'(IDX_MAX));
        send_item(MODE_WRITE, CH_BACKSPACE, IDX_W'(0));
        send_item(MODE_WRITE, 8'h41, IDX_W'(IDX_MAX));
        send_item(MODE_WRITE, 8'hFF, IDX_W'(0));
        send_item(MODE_WRITE, 8'h00, IDX_W'(0));
        send_item(MODE_READ, 8'h00, IDX_W'(1));
        send_item(MODE_WRITE, CH_BACKSPACE, IDX_W'(0));
        send_item(MODE_READ, 8'h00, IDX_W'(2));
        send_item(MODE_WRITE, CH_NEWLINE, IDX_W'(0));
        send_item(MODE_WRITE, 8'h7E, IDX_W'(0));
        send_item(MODE_READ, 8'h00, IDX_W'(COLUMNS));
        send_item(MODE_UNUSED, 8'hFF, IDX_W'(IDX_MAX));
        send_item(MODE_CLEAR, 8'hFF, IDX_W'(IDX_MAX));
        send_item(MODE_READ, 8'h00, IDX_W'(0));
        send_item(MODE_READ, 8'h00, IDX_W'(CELLS - 1));
        send_item(MODE_WRITE, CH_NEWLINE, IDX_W'(0));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: set_colors(4'h0, 4'hF);
                1: set_colors(4'hF, 4'hF);
                2: set_colors(4'h0, 4'h0);
                default: set_colors(COLOR_W'($urandom_range(0, 15)),
                                    COLOR_W'($urandom_range(0, 15)));
            endcase
            if (p == PHASES - 1)
                idle_on = 1'b0;
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
                random_step();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d items: %0d character writes, %0d cell reads, %0d clears, %0d unused.",
                 n_sent, n_chars, n_reads, n_clears, n_unused);
        $display("Checked %0d results over %0d colour settings; %0d screen scrolls were exercised.",
                 checked_count, PHASES + 1, scroll_count);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer_top.sv
verif/text_console_writer_checker.sv
verif/text_console_writer_top_test.sv
